>>> hw/rtl/utf8_byte_stream_decoder_unit_assert.svh
// Assertion helpers for the UTF-8 decoder unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UTF8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define U8D_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define U8D_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, constants and types for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [CpW-1:0] CpMax        = 21'h1FFFFF;
  localparam logic [CpW-1:0] SurrogateLo  = 21'h00D800;
  localparam logic [CpW-1:0] SurrogateHi  = 21'h00DFFF;

  localparam logic [ByteW-1:0] LeadC0     = 8'hC0;
  localparam logic [ByteW-1:0] LeadC1     = 8'hC1;
  localparam logic [ByteW-1:0] LeadBadMin = 8'hF5;

  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  // Result of decoding one byte against the current sequence state.
  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   code_point;
    logic [PendW-1:0] pending_nxt;
    logic [CpW-1:0]   partial_nxt;
  } dec_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/utf8_byte_stream_decoder_unit.sv
// A byte passes the input register, then is decoded into the result register.
// Throughput: one byte per cycle while the result register is not stalled;
//   the one-byte decode step sets the rate.
// A byte that yields no code point occupies no output slot.
// Reset (rst_n low, synchronous): pipeline emptied, no sequence pending,
//   max_code_point back to 0x1FFFFF.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Streaming UTF-8 decoder: bytes in, code points out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [u8d_pkg::ByteW-1:0] in_byte_in,
  input  wire logic                      in_last_byte,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [u8d_pkg::CpW-1:0]   out_code_point,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [u8d_pkg::CpW-1:0]   cfg_max_code_point
);

  `include "utf8_byte_stream_decoder_unit_assert.svh"

  logic                      ib_valid_r;
  logic [u8d_pkg::ByteW-1:0] ib_byte_r;
  logic                      ib_last_r;
  logic [u8d_pkg::PendW-1:0] pending_r;
  logic [u8d_pkg::CpW-1:0]   partial_r;
  logic [u8d_pkg::CpW-1:0]   max_cp_r;
  logic                      out_valid_r;
  logic [u8d_pkg::CpW-1:0]   out_cp_r;
  logic                      fire;
  u8d_pkg::dec_res_t         dec;

  // decode whenever the result slot is free or draining this cycle
  assign fire      = ib_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = ib_valid_r && !fire;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;

  u8d_decode u_decode (
    .byte_i   (ib_byte_r),
    .last_i   (ib_last_r),
    .pending_i(pending_r),
    .partial_i(partial_r),
    .max_cp_i (max_cp_r),
    .res_o    (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (!in_stall) begin
      ib_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_byte_r <= in_byte_in;
      ib_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= u8d_pkg::PendNone;
      partial_r <= '0;
    end else if (fire) begin
      pending_r <= dec.pending_nxt;
      partial_r <= dec.partial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r <= u8d_pkg::CpMax;
    end else if (cfg_valid && cfg_ready) begin
      max_cp_r <= cfg_max_code_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= dec.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && dec.emit) begin
      out_cp_r <= dec.code_point;
    end
  end

  `U8D_ASSERT_NEXT(a_last_clears, fire && ib_last_r,
    (pending_r == u8d_pkg::PendNone) && (partial_r == '0),
    "sequence state not cleared after last byte")

  `U8D_ASSERT_NOW(a_no_surrogate, out_valid_r,
    (out_cp_r < u8d_pkg::SurrogateLo) || (out_cp_r > u8d_pkg::SurrogateHi),
    "surrogate value presented on output")

  `U8D_ASSERT_NEXT(a_emit_lands, fire && dec.emit,
    out_valid_r,
    "decoded code point did not reach the result register")

  `U8D_ASSERT_NOW(a_stall_only_full, in_stall,
    ib_valid_r && out_valid_r && out_stall,
    "input stalled without a blocked result")

endmodule

`default_nettype wire

>>> hw/rtl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Single-byte decode step: next sequence state and optional code point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
  input  wire logic [u8d_pkg::ByteW-1:0] byte_i,
  input  wire logic                      last_i,
  input  wire logic [u8d_pkg::PendW-1:0] pending_i,
  input  wire logic [u8d_pkg::CpW-1:0]   partial_i,
  input  wire logic [u8d_pkg::CpW-1:0]   max_cp_i,
  output u8d_pkg::dec_res_t              res_o
);

  logic [u8d_pkg::CpW-1:0]   cont_val;
  logic [u8d_pkg::PendW-1:0] cont_pend;
  logic                      cont_ok;

  assign cont_val  = {partial_i[u8d_pkg::CpW-7:0], byte_i[5:0]};
  assign cont_pend = pending_i - u8d_pkg::PendOne;
  assign cont_ok   = (cont_pend == u8d_pkg::PendNone)
                   && ((cont_val < u8d_pkg::SurrogateLo) || (cont_val > u8d_pkg::SurrogateHi))
                   && (cont_val <= max_cp_i);

  always_comb begin
    res_o.emit        = 1'b0;
    res_o.code_point  = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_i};
    res_o.pending_nxt = pending_i;
    res_o.partial_nxt = partial_i;

    if (byte_i == '0) begin
      res_o.pending_nxt = u8d_pkg::PendNone;
    end else if (!byte_i[7]) begin
      res_o.pending_nxt = u8d_pkg::PendNone;
      res_o.emit        = 1'b1;
    end else if (byte_i[7:6] == 2'b10) begin
      // stray continuation leaves state untouched
      if (pending_i != u8d_pkg::PendNone) begin
        res_o.partial_nxt = cont_val;
        res_o.pending_nxt = cont_pend;
        res_o.code_point  = cont_val;
        res_o.emit        = cont_ok;
      end
    end else if ((byte_i == u8d_pkg::LeadC0) || (byte_i == u8d_pkg::LeadC1)
                 || (byte_i >= u8d_pkg::LeadBadMin)) begin
      res_o.pending_nxt = u8d_pkg::PendNone;
    end else if (byte_i[7:5] == 3'b110) begin
      res_o.pending_nxt = u8d_pkg::PendOne;
      res_o.partial_nxt = {{(u8d_pkg::CpW-5){1'b0}}, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      res_o.pending_nxt = u8d_pkg::PendTwo;
      res_o.partial_nxt = {{(u8d_pkg::CpW-4){1'b0}}, byte_i[3:0]};
    end else begin
      res_o.pending_nxt = u8d_pkg::PendThree;
      res_o.partial_nxt = {{(u8d_pkg::CpW-3){1'b0}}, byte_i[2:0]};
    end

    // end of string: drop whatever is pending
    if (last_i) begin
      res_o.pending_nxt = u8d_pkg::PendNone;
      res_o.partial_nxt = '0;
    end
  end

endmodule

`default_nettype wire
